// ===== rtl/core/sfd_pkg.sv =====
// sfd_pkg: types and fixed constants of the serial frame deframer
// item structs, result kind codes, header bytes and register indexes
// no dependencies
package sfd_pkg;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_GOOD     = 3'd2,
    KIND_BAD_CSUM = 3'd3,
    KIND_OVERRUN  = 3'd4,
    KIND_HDR_BAD  = 3'd5,
    KIND_SHORT    = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0]  rx_data;
    logic [15:0] idle_us;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  msg_type;
    logic [15:0] payload_len;
    logic [7:0]  frame_num;
    logic [7:0]  seq_byte;
    logic        ack_needed;
    logic        missed_frame;
    logic        message_done;
    logic [15:0] message_len;
  } out_item_t;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_US    = 1'd1;

  localparam logic [7:0]  SYNC_RESET = 8'h1e;
  localparam logic [15:0] GAP_RESET  = 16'd5000;

  // header and type constants
  localparam logic [7:0] DEST_ADDR  = 8'h0c;
  localparam logic [7:0] SRC_ADDR   = 8'h00;
  localparam logic [7:0] TYPE_ACK   = 8'h7f;
  localparam logic [7:0] TYPE_PASS  = 8'hf1;
  localparam int unsigned SEQ_FIRST_BIT = 6;

endpackage

// ===== rtl/core/serial_frame_deframer_reassembly_core.sv =====
// serial_frame_deframer_reassembly_core: byte deframer with per-type reassembly table
// depends on sfd_pkg
//
// usage: the input channel carries one received byte with its idle time per item;
// the output channel returns exactly one status item per input item, in order.
// throughput is one item per cycle unless out_stall_i holds the input; an item's result
// goes into the output register when it is accepted. the per-type table (frames left,
// message length) sits in one synchronous memory; the entry for a frame is read when the
// type byte is accepted and written back when the last checksum byte of a good non-ACK,
// non-PASS frame is accepted, so the single memory port never limits the rate.
// in_stall_o follows out_stall_i only while the output register holds an item,
// so a new item is taken in the same cycle the previous result is taken.
// reset puts the block in sync search, loads the register reset values and
// clears the table at once through per-entry valid bits; no clearing pass.
// configuration writes take effect at the next edge and are meant for idle time.
module serial_frame_deframer_reassembly_core #(
  parameter int unsigned MAX_FRAME = 256,
  parameter int unsigned NUM_TYPES = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  sfd_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output sfd_pkg::out_item_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned BW = $clog2(MAX_FRAME + 1);
  localparam int unsigned SW = $clog2(NUM_TYPES);
  localparam logic [BW-1:0] IdxMax = BW'(MAX_FRAME);

  localparam logic [2:0] PH_SYNC    = 3'd0;
  localparam logic [2:0] PH_DISCARD = 3'd1;
  localparam logic [2:0] PH_DEST    = 3'd2;
  localparam logic [2:0] PH_SRC     = 3'd3;
  localparam logic [2:0] PH_TYPE    = 3'd4;
  localparam logic [2:0] PH_LEN1    = 3'd5;
  localparam logic [2:0] PH_LEN2    = 3'd6;
  localparam logic [2:0] PH_BODY    = 3'd7;

  // type byte to table slot, type modulo the table depth
  function automatic logic [256*SW-1:0] slot_lut();
    logic [256*SW-1:0] lut;
    int unsigned       r;
    lut = '0;
    r   = 0;
    for (int unsigned k = 0; k < 256; k++) begin
      lut[k*SW +: SW] = SW'(r);
      r = (r + 1 == NUM_TYPES) ? 0 : r + 1;
    end
    return lut;
  endfunction

  localparam logic [256*SW-1:0] SlotLut = slot_lut();

  // configuration
  logic [7:0]  sync_q;
  logic [15:0] gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= sfd_pkg::SYNC_RESET;
      gap_q  <= sfd_pkg::GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfd_pkg::REG_SYNC_BYTE: sync_q <= cfg_data_i[7:0];
        sfd_pkg::REG_GAP_US:    gap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame state
  logic [2:0]    phase_q, phase_d;
  logic [7:0]    even_q, even_d;
  logic [7:0]    odd_q, odd_d;
  logic [7:0]    type_q, type_d;
  logic [15:0]   len_q, len_d;
  logic [BW-1:0] idx_q, idx_d;
  logic [7:0]    tfr_q, tfr_d;
  logic [7:0]    tsq_q, tsq_d;
  logic [SW-1:0] slot_q;

  // reassembly table: {frames_left, msg_length}
  logic [23:0]          tbl_mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] tbl_vld_q;
  logic [23:0]          rd_q;
  logic                 rd_vld_q;
  logic                 rd_en, wr_en;
  logic [SW-1:0]        rd_slot;
  logic [23:0]          wr_data;

  logic                 out_valid_q;
  sfd_pkg::out_item_t   out_q, res;
  logic                 in_acc;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rd_slot     = SlotLut[32'(in_data_i.rx_data) * SW +: SW];

  always_comb begin
    logic [7:0]  b;
    logic [16:0] idx_ext;
    logic [16:0] len_ext;
    logic [16:0] total;
    logic [15:0] len_m2;
    logic [7:0]  ev_n, od_n;
    logic [7:0]  base_fl, new_fl;
    logic [15:0] base_ml, new_ml;
    logic        first;
    b       = in_data_i.rx_data;
    idx_ext = 17'(idx_q);
    len_ext = {1'b0, len_q};
    total   = len_ext + 17'(len_q[0]) + 17'd2;
    len_m2  = len_q - 16'd2;
    ev_n    = idx_q[0] ? even_q : (even_q ^ b);
    od_n    = idx_q[0] ? (odd_q ^ b) : odd_q;
    first   = tsq_q[sfd_pkg::SEQ_FIRST_BIT];
    base_fl = first ? tfr_q : (rd_vld_q ? rd_q[23:16] : 8'h00);
    base_ml = first ? 16'h0000 : (rd_vld_q ? rd_q[15:0] : 16'h0000);
    new_fl  = base_fl - 8'd1;
    new_ml  = base_ml + len_m2;
    wr_data = {new_fl, new_ml};

    phase_d = phase_q;
    even_d  = even_q;
    odd_d   = odd_q;
    type_d  = type_q;
    len_d   = len_q;
    idx_d   = idx_q;
    tfr_d   = tfr_q;
    tsq_d   = tsq_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    res     = '0;

    unique case (phase_q) inside
      PH_SYNC, PH_DISCARD: begin
        if (phase_q == PH_SYNC || in_data_i.idle_us >= gap_q) begin
          if (b == sync_q) begin
            even_d  = b;
            odd_d   = 8'h00;
            phase_d = PH_DEST;
          end else if (phase_q == PH_SYNC) begin
            phase_d = PH_DISCARD;
          end
        end
      end
      PH_DEST: begin
        odd_d = odd_q ^ b;
        if (b != sfd_pkg::DEST_ADDR) begin
          res.kind = sfd_pkg::KIND_HDR_BAD;
          phase_d  = PH_SYNC;
        end else begin
          phase_d = PH_SRC;
        end
      end
      PH_SRC: begin
        even_d = even_q ^ b;
        if (b != sfd_pkg::SRC_ADDR) begin
          res.kind = sfd_pkg::KIND_HDR_BAD;
          phase_d  = PH_SYNC;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        odd_d   = odd_q ^ b;
        type_d  = b;
        rd_en   = 1'b1;  // fetch the table entry long before frame end
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        even_d  = even_q ^ b;
        len_d   = {b, 8'h00};
        phase_d = PH_LEN2;
      end
      PH_LEN2: begin
        odd_d = odd_q ^ b;
        len_d = {len_q[15:8], b};
        idx_d = '0;
        tfr_d = 8'h00;
        tsq_d = 8'h00;
        if ({len_q[15:8], b} < 16'd2) begin
          res.kind     = sfd_pkg::KIND_SHORT;
          res.msg_type = type_q;
          phase_d      = PH_SYNC;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (idx_q >= IdxMax) begin
          res.kind        = sfd_pkg::KIND_OVERRUN;
          res.msg_type    = type_q;
          res.payload_len = len_m2;
          phase_d         = PH_SYNC;
        end else begin
          even_d = ev_n;
          odd_d  = od_n;
          if (idx_ext + 17'd2 < len_ext) begin
            res.kind        = sfd_pkg::KIND_PAYLOAD;
            res.data_byte   = b;
            res.msg_type    = type_q;
            res.payload_len = len_m2;
          end else if (idx_ext + 17'd2 == len_ext) begin
            tfr_d = b;
          end else if (idx_ext + 17'd1 == len_ext) begin
            tsq_d = b;
          end
          idx_d = idx_q + 1'b1;
          if (idx_ext + 17'd1 == total) begin
            phase_d         = PH_SYNC;
            res.msg_type    = type_q;
            res.payload_len = len_m2;
            res.frame_num   = tfr_q;
            res.seq_byte    = tsq_q;
            if (ev_n != 8'h00 || od_n != 8'h00) begin
              res.kind = sfd_pkg::KIND_BAD_CSUM;
            end else begin
              res.kind = sfd_pkg::KIND_GOOD;
              if (type_q != sfd_pkg::TYPE_ACK && type_q != sfd_pkg::TYPE_PASS) begin
                wr_en            = 1'b1;
                res.ack_needed   = 1'b1;
                res.missed_frame = ~first & (base_fl != tfr_q);
                res.message_done = (new_fl == 8'h00);
                res.message_len  = new_ml;
              end
            end
          end
        end
      end
      default: phase_d = PH_SYNC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC;
      even_q      <= 8'h00;
      odd_q       <= 8'h00;
      type_q      <= 8'h00;
      len_q       <= 16'h0000;
      idx_q       <= '0;
      tfr_q       <= 8'h00;
      tsq_q       <= 8'h00;
      tbl_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        even_q  <= even_d;
        odd_q   <= odd_d;
        type_q  <= type_d;
        len_q   <= len_d;
        idx_q   <= idx_d;
        tfr_q   <= tfr_d;
        tsq_q   <= tsq_d;
        if (rd_en) begin
          rd_vld_q <= tbl_vld_q[rd_slot];
        end
        if (wr_en) begin
          tbl_vld_q[slot_q] <= 1'b1;
        end
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // table memory and payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
      if (rd_en) begin
        rd_q   <= tbl_mem[rd_slot];
        slot_q <= rd_slot;
      end
      if (wr_en) begin
        tbl_mem[slot_q] <= wr_data;
      end
    end
  end

endmodule

// ===== rtl/core/sfd_checker.sv =====
// sfd_checker: port-level checks for serial_frame_deframer_reassembly_core
// depends on sfd_pkg; bound to the top level below
module sfd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input sfd_pkg::out_item_t             out_data_o
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  // an empty output register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  // every accepted item yields a result on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // table fields only on good frames
  a_table_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != sfd_pkg::KIND_GOOD |->
      !out_data_o.ack_needed && !out_data_o.missed_frame && !out_data_o.message_done
      && out_data_o.message_len == 16'h0000)
    else $error("table fields set outside a good frame");

endmodule

bind serial_frame_deframer_reassembly_core sfd_checker u_sfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
